// ===== hdl/mmtp_pkg.sv =====
// Shared types, constants and lookup functions of the music macro tune parser.
// No dependencies; the top level and the divider import this package.
package mmtp_pkg;

  localparam int unsigned DivW     = 28;
  localparam int unsigned DivCntW  = $clog2(DivW);
  localparam int unsigned PeriodW  = 23;
  localparam int unsigned DurW     = 24;
  localparam logic [DivW-1:0] WholeUs  = 28'd240000000;
  localparam logic [DurW:0]   DurMax   = 25'd16000000;
  localparam logic [4:0]      MaxDots  = 5'd31;
  // Reciprocal of 100 scaled by 2^22; exact for products below 2^15.
  localparam logic [15:0]     LoudRecip = 16'd41944;
  localparam int unsigned     LoudShift = 22;
  localparam logic [7:0]      LoudMax  = 8'd255;
  localparam logic [7:0]      TempoMin = 8'd32;
  localparam logic [7:0]      NoteMax  = 8'd84;
  localparam logic [2:0]      OctMax   = 3'd6;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_CHAR  = 2'd1,
    FUNC_END   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_TONE  = 2'd0,
    KIND_SIL   = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_READY,
    PH_MODE,
    PH_ACC,
    PH_NUM,
    PH_DOTS
  } phase_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_V,
    CMD_L,
    CMD_O,
    CMD_T,
    CMD_N,
    CMD_R,
    CMD_A
  } cmd_e;

  typedef enum logic [1:0] {
    ART_NORMAL   = 2'd0,
    ART_LEGATO   = 2'd1,
    ART_STACCATO = 2'd2
  } artic_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  note_index;
    logic [16:0] freq_q4;
    logic [7:0]  loudness;
    logic [23:0] duration_us;
    logic        repeat_requested;
  } res_t;

  // Semitone of a note letter within its octave, letters A to G.
  function automatic logic [3:0] letter_semitone(input logic [2:0] idx);
    logic [3:0] s;
    unique case (idx)
      3'd0:    s = 4'd9;
      3'd1:    s = 4'd11;
      3'd2:    s = 4'd0;
      3'd3:    s = 4'd2;
      3'd4:    s = 4'd4;
      3'd5:    s = 4'd5;
      3'd6:    s = 4'd7;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // Tone frequency in sixteenths of a hertz for notes 1 to 84.
  function automatic logic [16:0] note_freq(input logic [6:0] n);
    logic [16:0] f;
    case (n)
      7'd1:  f = 17'd1047;   7'd2:  f = 17'd1109;   7'd3:  f = 17'd1175;
      7'd4:  f = 17'd1245;   7'd5:  f = 17'd1319;   7'd6:  f = 17'd1397;
      7'd7:  f = 17'd1480;   7'd8:  f = 17'd1568;   7'd9:  f = 17'd1661;
      7'd10: f = 17'd1760;   7'd11: f = 17'd1865;   7'd12: f = 17'd1976;
      7'd13: f = 17'd2093;   7'd14: f = 17'd2217;   7'd15: f = 17'd2349;
      7'd16: f = 17'd2489;   7'd17: f = 17'd2637;   7'd18: f = 17'd2794;
      7'd19: f = 17'd2960;   7'd20: f = 17'd3136;   7'd21: f = 17'd3322;
      7'd22: f = 17'd3520;   7'd23: f = 17'd3729;   7'd24: f = 17'd3951;
      7'd25: f = 17'd4186;   7'd26: f = 17'd4435;   7'd27: f = 17'd4699;
      7'd28: f = 17'd4978;   7'd29: f = 17'd5274;   7'd30: f = 17'd5588;
      7'd31: f = 17'd5920;   7'd32: f = 17'd6272;   7'd33: f = 17'd6645;
      7'd34: f = 17'd7040;   7'd35: f = 17'd7459;   7'd36: f = 17'd7902;
      7'd37: f = 17'd8372;   7'd38: f = 17'd8870;   7'd39: f = 17'd9397;
      7'd40: f = 17'd9956;   7'd41: f = 17'd10548;  7'd42: f = 17'd11175;
      7'd43: f = 17'd11840;  7'd44: f = 17'd12544;  7'd45: f = 17'd13290;
      7'd46: f = 17'd14080;  7'd47: f = 17'd14917;  7'd48: f = 17'd15804;
      7'd49: f = 17'd16744;  7'd50: f = 17'd17740;  7'd51: f = 17'd18795;
      7'd52: f = 17'd19912;  7'd53: f = 17'd21096;  7'd54: f = 17'd22351;
      7'd55: f = 17'd23680;  7'd56: f = 17'd25088;  7'd57: f = 17'd26580;
      7'd58: f = 17'd28160;  7'd59: f = 17'd29834;  7'd60: f = 17'd31609;
      7'd61: f = 17'd33488;  7'd62: f = 17'd35479;  7'd63: f = 17'd37589;
      7'd64: f = 17'd39824;  7'd65: f = 17'd42192;  7'd66: f = 17'd44701;
      7'd67: f = 17'd47359;  7'd68: f = 17'd50175;  7'd69: f = 17'd53159;
      7'd70: f = 17'd56320;  7'd71: f = 17'd59669;  7'd72: f = 17'd63217;
      7'd73: f = 17'd66976;  7'd74: f = 17'd70959;  7'd75: f = 17'd75178;
      7'd76: f = 17'd79649;  7'd77: f = 17'd84385;  7'd78: f = 17'd89402;
      7'd79: f = 17'd94719;  7'd80: f = 17'd100351; 7'd81: f = 17'd106318;
      7'd82: f = 17'd112640; 7'd83: f = 17'd119338; 7'd84: f = 17'd126434;
      default: f = 17'd0;
    endcase
    return f;
  endfunction

endpackage

// ===== hdl/mmtp_if.sv =====
// Valid/ready channel interfaces: tune characters in, events out, volume writes.
// Depends on nothing.
interface mmtp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] char_code;
  modport source (output valid, func, char_code, input ready);
  modport sink (input valid, func, char_code, output ready);
endinterface

interface mmtp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [6:0]  note_index;
  logic [16:0] freq_q4;
  logic [7:0]  loudness;
  logic [23:0] duration_us;
  logic        repeat_requested;
  logic        last;
  modport source (output valid, kind, note_index, freq_q4, loudness, duration_us,
                  repeat_requested, last, input ready);
  modport sink (input valid, kind, note_index, freq_q4, loudness, duration_us,
                repeat_requested, last, output ready);
endinterface

interface mmtp_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hdl/music_macro_tune_parser_unit.sv =====
// Top level of the music macro tune parser: parse sequencer, event buffer, volume register.
// Depends on mmtp_pkg, the channel interfaces in mmtp_if and the divider mmtp_div.

// Characters are taken one per request while the parser is idle. A character that finishes
// a note or rest runs the shared divider twice (whole note by tempo, then by length), then
// adds the extension once per dot, then for a tone scales the loudness. Up to three events
// are buffered and then drained, one per accepted request; the parser takes no new
// character until the last of them is gone.
module music_macro_tune_parser_unit import mmtp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mmtp_in_if.sink    tune_i,
  mmtp_out_if.source evt_o,
  mmtp_cfg_if.sink   cfg_i
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_FEED  = 12'b0000_0000_0010,
    S_DIVT  = 12'b0000_0000_0100,
    S_WAITT = 12'b0000_0000_1000,
    S_DIVL  = 12'b0000_0001_0000,
    S_WAITL = 12'b0000_0010_0000,
    S_ARTIC = 12'b0000_0100_0000,
    S_DOTS  = 12'b0000_1000_0000,
    S_LOUDS = 12'b0001_0000_0000,
    S_LOUDW = 12'b0010_0000_0000,
    S_GAP   = 12'b0100_0000_0000,
    S_DRAIN = 12'b1000_0000_0000
  } state_e;

  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;
  cmd_e               cmd_q, cmd_d;
  artic_e             artic_q, artic_d;
  logic [7:0]         acc_q, acc_d;
  logic [4:0]         dots_q, dots_d;
  logic [7:0]         tempo_q, tempo_d;
  logic [7:0]         dlen_q, dlen_d;
  logic [2:0]         oct_q, oct_d;
  logic [7:0]         vol_q, vol_d;
  logic               rep_q, rep_d;
  logic [6:0]         note_q, note_d;
  logic               halted_q, halted_d;
  logic [6:0]         pct_q;
  logic [7:0]         c_q, c_d;
  logic [PeriodW-1:0] period_q, period_d;
  logic [PeriodW-1:0] gap_q, gap_d;
  logic [DurW:0]      base_q, base_d;
  logic [DurW-1:0]    ext_q, ext_d;
  logic [4:0]         dcnt_q, dcnt_d;
  logic [14:0]        prod_q, prod_d;
  res_t               res_q [3];
  res_t               res_d [3];
  logic [1:0]         cnt_q, cnt_d;

  logic               push;
  res_t               push_val;
  logic               div_start, div_done;
  logic [DivW-1:0]    div_dividend, div_quot;
  logic [7:0]         div_divisor;
  logic [14:0]        vol_prod;
  logic [30:0]        loud_mul;
  logic [7:0]         c_up, c, len;
  logic               is_digit, fin_done;
  logic [3:0]         digit;
  logic [2:0]         letter;
  logic [DurW:0]      dot_sum, art_base;
  logic [PeriodW-1:0] art_gap;
  logic [8:0]         loud_full;

  mmtp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign c        = c_q;
  assign is_digit = (c >= "0") && (c <= "9");
  assign digit    = 4'(c - "0");
  assign letter   = 3'(c - "A");
  assign c_up     = ((tune_i.char_code >= "a") && (tune_i.char_code <= "z")) ?
                    8'(tune_i.char_code - 8'd32) : tune_i.char_code;
  assign len      = ((cmd_q == CMD_R) && (acc_q == 8'd0)) ? 8'd1 : acc_q;
  assign vol_prod = vol_q * pct_q;
  assign dot_sum  = base_q + {1'b0, ext_q};
  // The registered product is divided by 100 through the scaled reciprocal.
  assign loud_mul  = prod_q * LoudRecip;
  assign loud_full = 9'(loud_mul >> LoudShift);

  always_comb begin
    art_gap = '0;
    if (cmd_q != CMD_R) begin
      unique case (artic_q)
        ART_STACCATO: art_gap = period_q >> 2;
        ART_LEGATO:   art_gap = '0;
        default:      art_gap = period_q >> 3;
      endcase
    end
    art_base = (DurW+1)'(period_q - art_gap);
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = WholeUs;
    div_divisor  = tempo_q;
    unique case (state_q)
      S_DIVT: div_start = 1'b1;
      S_DIVL: begin
        div_start    = 1'b1;
        div_dividend = DivW'(period_q);
        div_divisor  = len;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    artic_d  = artic_q;
    acc_d    = acc_q;
    dots_d   = dots_q;
    tempo_d  = tempo_q;
    dlen_d   = dlen_q;
    oct_d    = oct_q;
    vol_d    = vol_q;
    rep_d    = rep_q;
    note_d   = note_q;
    halted_d = halted_q;
    c_d      = c_q;
    period_d = period_q;
    gap_d    = gap_q;
    base_d   = base_q;
    ext_d    = ext_q;
    dcnt_d   = dcnt_q;
    prod_d   = prod_q;
    res_d    = res_q;
    cnt_d    = cnt_q;
    push     = 1'b0;
    push_val = '0;
    fin_done = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (tune_i.valid) begin
          if (tune_i.func == FUNC_START) begin
            phase_d  = PH_READY;
            cmd_d    = CMD_NONE;
            acc_d    = '0;
            dots_d   = '0;
            tempo_d  = 8'd120;
            dlen_d   = 8'd4;
            oct_d    = 3'd4;
            vol_d    = 8'd255;
            artic_d  = ART_NORMAL;
            rep_d    = 1'b0;
            note_d   = '0;
            halted_d = 1'b0;
          end else if (!halted_q && tune_i.func == FUNC_END) begin
            c_d     = 8'd0;
            state_d = S_FEED;
          end else if (!halted_q && tune_i.func == FUNC_CHAR) begin
            if (!(c_up == 8'd32 || (c_up >= 8'd9 && c_up <= 8'd13))) begin
              c_d     = c_up;
              state_d = S_FEED;
            end
          end
        end
      end

      S_FEED: begin
        // One pass of the character parser; passes that reparse the same
        // character stay in this state with the new phase.
        unique case (phase_q)
          PH_READY: begin
            fin_done = 1'b1;
            if (c == 8'd0) begin
              push     = 1'b1;
              push_val.kind = KIND_END;
              push_val.repeat_requested = rep_q;
              halted_d = 1'b1;
              phase_d  = PH_IDLE;
            end else begin
              acc_d  = '0;
              dots_d = '0;
              priority case (1'b1)
                c == "V": begin cmd_d = CMD_V; phase_d = PH_NUM; end
                c == "L": begin cmd_d = CMD_L; phase_d = PH_NUM; end
                c == "O": begin cmd_d = CMD_O; phase_d = PH_NUM; end
                c == "T": begin cmd_d = CMD_T; phase_d = PH_NUM; end
                c == "N": begin cmd_d = CMD_N; phase_d = PH_NUM; end
                c == "R" || c == "P": begin cmd_d = CMD_R; phase_d = PH_NUM; end
                c == "<": if (oct_q != 3'd0) oct_d = oct_q - 1'b1;
                c == ">": if (oct_q < OctMax) oct_d = oct_q + 1'b1;
                c == "M": phase_d = PH_MODE;
                c >= "A" && c <= "G": begin
                  cmd_d   = CMD_A;
                  note_d  = 7'(letter_semitone(letter)) + {1'b0, oct_q, 3'b000}
                            + {2'b00, oct_q, 2'b00} + 7'd1;
                  phase_d = PH_ACC;
                end
                default: begin
                  push = 1'b1; push_val.kind = KIND_ERROR;
                  halted_d = 1'b1; phase_d = PH_IDLE;
                end
              endcase
            end
          end
          PH_MODE: begin
            fin_done = 1'b1;
            phase_d  = PH_READY;
            priority case (1'b1)
              c == "N": artic_d = ART_NORMAL;
              c == "L": artic_d = ART_LEGATO;
              c == "S": artic_d = ART_STACCATO;
              c == "F": rep_d = 1'b0;
              c == "B": rep_d = 1'b1;
              default: begin
                push = 1'b1; push_val.kind = KIND_ERROR;
                halted_d = 1'b1; phase_d = PH_IDLE;
              end
            endcase
          end
          PH_ACC: begin
            phase_d = PH_NUM;
            acc_d   = '0;
            if (c == "#" || c == "+") begin
              fin_done = 1'b1;
              if (note_q < 7'(NoteMax)) note_d = note_q + 1'b1;
            end else if (c == "-") begin
              fin_done = 1'b1;
              if (note_q > 7'd1) note_d = note_q - 1'b1;
            end
          end
          PH_NUM: begin
            if (is_digit) begin
              fin_done = 1'b1;
              acc_d = 8'({acc_q, 3'b000} + {acc_q, 1'b0} + {4'b0, digit});
            end else begin
              phase_d = PH_READY;
              unique case (cmd_q)
                CMD_V: vol_d = acc_q;
                CMD_L: begin
                  if (acc_q == 8'd0) begin
                    fin_done = 1'b1; push = 1'b1; push_val.kind = KIND_ERROR;
                    halted_d = 1'b1; phase_d = PH_IDLE;
                  end else begin
                    dlen_d = acc_q;
                  end
                end
                CMD_O: oct_d = (acc_q > 8'(OctMax)) ? OctMax : acc_q[2:0];
                CMD_T: begin
                  if (acc_q < TempoMin) begin
                    fin_done = 1'b1; push = 1'b1; push_val.kind = KIND_ERROR;
                    halted_d = 1'b1; phase_d = PH_IDLE;
                  end else begin
                    tempo_d = acc_q;
                  end
                end
                CMD_N: begin
                  if (acc_q > NoteMax) begin
                    fin_done = 1'b1; push = 1'b1; push_val.kind = KIND_ERROR;
                    halted_d = 1'b1; phase_d = PH_IDLE;
                  end else begin
                    if (acc_q == 8'd0) begin
                      cmd_d = CMD_R;
                      acc_d = '0;
                    end else begin
                      cmd_d  = CMD_A;
                      note_d = acc_q[6:0];
                      acc_d  = dlen_q;
                    end
                    dots_d  = '0;
                    phase_d = PH_DOTS;
                  end
                end
                CMD_R: begin
                  dots_d  = '0;
                  phase_d = PH_DOTS;
                end
                CMD_A: begin
                  if (acc_q == 8'd0) acc_d = dlen_q;
                  dots_d  = '0;
                  phase_d = PH_DOTS;
                end
                default: ;
              endcase
            end
          end
          PH_DOTS: begin
            if (c == ".") begin
              fin_done = 1'b1;
              if (dots_q < MaxDots) dots_d = dots_q + 1'b1;
            end else begin
              phase_d = PH_READY;
              state_d = S_DIVT;
            end
          end
          default: fin_done = 1'b1;
        endcase
      end

      S_DIVT:  state_d = S_WAITT;
      S_WAITT: begin
        if (div_done) begin
          period_d = div_quot[PeriodW-1:0];
          state_d  = S_DIVL;
        end
      end
      S_DIVL:  state_d = S_WAITL;
      S_WAITL: begin
        if (div_done) begin
          period_d = div_quot[PeriodW-1:0];
          state_d  = S_ARTIC;
        end
      end
      S_ARTIC: begin
        gap_d   = art_gap;
        base_d  = art_base;
        ext_d   = art_base[DurW:1];
        dcnt_d  = dots_q;
        state_d = S_DOTS;
      end
      S_DOTS: begin
        // Each dot adds the current extension, which halves for the next dot.
        if (dcnt_q == 5'd0) begin
          if (cmd_q == CMD_R) begin
            push = 1'b1;
            push_val.kind = KIND_SIL;
            push_val.duration_us = base_q[DurW-1:0];
            state_d = S_FEED;
          end else begin
            state_d = S_LOUDS;
          end
        end else begin
          base_d = (dot_sum > DurMax) ? DurMax : dot_sum;
          ext_d  = ext_q >> 1;
          dcnt_d = dcnt_q - 1'b1;
        end
      end
      S_LOUDS: begin
        prod_d  = vol_prod;
        state_d = S_LOUDW;
      end
      S_LOUDW: begin
        push = (note_q >= 7'd1) && (note_q <= 7'(NoteMax));
        push_val.kind        = KIND_TONE;
        push_val.note_index  = note_q;
        push_val.freq_q4     = note_freq(note_q);
        push_val.loudness    = (loud_full > 9'(LoudMax)) ? LoudMax : loud_full[7:0];
        push_val.duration_us = base_q[DurW-1:0];
        state_d = (gap_q != '0) ? S_GAP : S_FEED;
      end
      S_GAP: begin
        push = 1'b1;
        push_val.kind = KIND_SIL;
        push_val.duration_us = DurW'(gap_q);
        state_d = S_FEED;
      end
      S_DRAIN: begin
        if (evt_o.ready) begin
          res_d[0] = res_q[1];
          res_d[1] = res_q[2];
          cnt_d    = cnt_q - 1'b1;
          if (cnt_q == 2'd1) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (push && cnt_q != 2'd3) begin
      res_d[cnt_q] = push_val;
      cnt_d        = cnt_q + 1'b1;
    end
    if (fin_done) state_d = (cnt_d != 2'd0) ? S_DRAIN : S_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_IDLE;
      cmd_q    <= CMD_NONE;
      artic_q  <= ART_NORMAL;
      acc_q    <= '0;
      dots_q   <= '0;
      tempo_q  <= 8'd120;
      dlen_q   <= 8'd4;
      oct_q    <= 3'd4;
      vol_q    <= 8'd255;
      rep_q    <= 1'b0;
      note_q   <= '0;
      halted_q <= 1'b1;
      pct_q    <= 7'd100;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      cmd_q    <= cmd_d;
      artic_q  <= artic_d;
      acc_q    <= acc_d;
      dots_q   <= dots_d;
      tempo_q  <= tempo_d;
      dlen_q   <= dlen_d;
      oct_q    <= oct_d;
      vol_q    <= vol_d;
      rep_q    <= rep_d;
      note_q   <= note_d;
      halted_q <= halted_d;
      cnt_q    <= cnt_d;
      if (cfg_i.valid) pct_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q      <= c_d;
    period_q <= period_d;
    gap_q    <= gap_d;
    base_q   <= base_d;
    ext_q    <= ext_d;
    dcnt_q   <= dcnt_d;
    prod_q   <= prod_d;
    res_q    <= res_d;
  end

  assign tune_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;

  assign evt_o.valid            = (state_q == S_DRAIN);
  assign evt_o.kind             = res_q[0].kind;
  assign evt_o.note_index       = res_q[0].note_index;
  assign evt_o.freq_q4          = res_q[0].freq_q4;
  assign evt_o.loudness         = res_q[0].loudness;
  assign evt_o.duration_us      = res_q[0].duration_us;
  assign evt_o.repeat_requested = res_q[0].repeat_requested;
  assign evt_o.last             = (cnt_q == 2'd1);

`ifndef SYNTHESIS
  a_drain_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.valid |-> cnt_q != 2'd0) else $error("event offered from an empty buffer");
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> cnt_q == 2'd0) else $error("parser idle with events left");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.valid && evt_o.ready && evt_o.last |=> state_q == S_IDLE)
    else $error("parser not idle after final event");
  a_div_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !div_done) else $error("divider done right after start");
`endif

endmodule

// ===== hdl/mmtp_div.sv =====
// Shared restoring divider, one quotient bit per cycle, 8-bit divisor.
// Depends on mmtp_pkg.
module mmtp_div import mmtp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [7:0]      divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [7:0]         rem_q, rem_d;
  logic [7:0]         dsr_q, dsr_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [8:0]         trial;
  logic               ge;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so the trial fits nine bits.
      rem_d = ge ? 8'(trial - {1'b0, dsr_q}) : trial[7:0];
      quo_d = {quo_q[DivW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
